### rtl/core/lfu_handle_cache_defines.svh
// Assertion macros for the handle cache.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LFU_HANDLE_CACHE_DEFINES_SVH
`define LFU_HANDLE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
`define LFU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LFU_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LFU_ASSERT(name, prop, msg)
`define LFU_ASSERT_NEVER(name, cond, msg)
`endif

`endif

### rtl/core/lfu_hc_pkg.sv
`default_nettype none

package lfu_hc_pkg;

  // request opcodes
  localparam logic OpLookup = 1'b0;
  localparam logic OpInsert = 1'b1;

  // response status codes
  localparam logic [2:0] StHit       = 3'd0;
  localparam logic [2:0] StMiss      = 3'd1;
  localparam logic [2:0] StInserted  = 3'd2;
  localparam logic [2:0] StEvicted   = 3'd3;
  localparam logic [2:0] StDuplicate = 3'd4;

  localparam int unsigned KeyFieldW    = 32;
  localparam int unsigned HandleFieldW = 64;

  typedef struct packed {
    logic                    op;
    logic [KeyFieldW-1:0]    key;
    logic [HandleFieldW-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [HandleFieldW-1:0] handle_out;
    logic [KeyFieldW-1:0]    evicted_key;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/lfu_handle_cache.sv
// LFU handle cache: a small fully associative key -> handle table with
// per-slot use counts and least-frequently-used replacement.
// Request channel (req_valid_i / req_ready_o / req_i): op selects lookup or
// insert; key and handle ride along. Response channel (rsp_valid_o /
// rsp_ready_i / rsp_o): exactly one response per request, in order.
// Slot data (key, handle, count) sits in one synchronous RAM; valid bits are
// flops. Every request scans all POOL_ENTRIES slots through the single RAM
// read port (one slot per cycle, registered read data), then a finish
// cycle writes back the count bump or the new entry and loads the response.
// The block takes no new request until the one in service leaves its finish
// cycle, so requests are served one at a time.
// req_ready_o is high while no request is in service, even if a response
// still waits in the output register; a new scan then holds in its finish
// cycle until the receiver takes the pending response.
// Reset clears all valid bits (empty table); RAM contents need no clearing.
`default_nettype none

`include "lfu_handle_cache_defines.svh"

module lfu_handle_cache #(
  parameter int unsigned POOL_ENTRIES = 10,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire lfu_hc_pkg::req_t  req_i,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output lfu_hc_pkg::rsp_t       rsp_o
);

  localparam int unsigned IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned HW     = lfu_hc_pkg::HandleFieldW;
  localparam int unsigned WORD_W = KEY_BITS + HW + COUNT_BITS;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(POOL_ENTRIES - 1);

  typedef enum logic [1:0] {StIdle, StScan, StDrain, StFinish} state_e;

  state_e state_q;

  // request being served
  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [HW-1:0]         handle_q;

  // scan pipeline: read issued with rd_idx_q, compared in the cycle after
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  cmp_vld_q;
  logic [IDX_W-1:0]      cmp_idx_q;

  // scan results
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [HW-1:0]         hit_handle_q;
  logic [COUNT_BITS-1:0] hit_uses_q;
  logic                  free_found_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic                  vic_found_q;
  logic [IDX_W-1:0]      vic_idx_q;
  logic [KEY_BITS-1:0]   vic_key_q;
  logic [COUNT_BITS-1:0] vic_uses_q;

  logic [POOL_ENTRIES-1:0] valid_q;

  logic                  rsp_valid_q;
  lfu_hc_pkg::rsp_t      rsp_q;

  // RAM ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [WORD_W-1:0]     ram_rdata;

  lfu_hc_ram #(
    .DEPTH (POOL_ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // unpack the word read back: {key, handle, uses}
  logic [KEY_BITS-1:0]   rd_key;
  logic [HW-1:0]         rd_handle;
  logic [COUNT_BITS-1:0] rd_uses;
  assign rd_key    = ram_rdata[WORD_W-1 -: KEY_BITS];
  assign rd_handle = ram_rdata[COUNT_BITS +: HW];
  assign rd_uses   = ram_rdata[COUNT_BITS-1:0];

  // incoming key narrowed or zero-extended to KEY_BITS
  logic [63:0]         req_key_ext;
  logic [KEY_BITS-1:0] req_key;
  assign req_key_ext = {32'b0, req_i.key};
  assign req_key     = req_key_ext[KEY_BITS-1:0];

  logic req_fire;
  logic fin_go;
  assign req_ready_o = (state_q == StIdle);
  assign req_fire    = req_valid_i && req_ready_o;
  assign fin_go      = (state_q == StFinish) && (!rsp_valid_q || rsp_ready_i);
  assign ram_re      = (state_q == StScan);

  // per-slot compare on the returning read
  logic slot_valid;
  logic slot_match;
  logic slot_free;
  logic vic_take;
  always_comb begin
    slot_valid = valid_q[cmp_idx_q];
    slot_match = cmp_vld_q && slot_valid && (rd_key == key_q);
    slot_free  = cmp_vld_q && !slot_valid && !free_found_q;
    vic_take   = cmp_vld_q && slot_valid &&
                 (!vic_found_q || (rd_uses < vic_uses_q) ||
                  ((rd_uses == vic_uses_q) && (rd_key < vic_key_q)));
  end

  // finish cycle: decide the outcome and the write-back
  logic [COUNT_BITS-1:0] uses_inc;
  logic [63:0]           ev_ext;
  lfu_hc_pkg::rsp_t      rsp_d;
  logic                  do_insert;
  always_comb begin
    uses_inc  = (&hit_uses_q) ? hit_uses_q : hit_uses_q + COUNT_BITS'(1);
    ev_ext    = '0;
    ev_ext[KEY_BITS-1:0] = vic_key_q;
    rsp_d     = '0;
    do_insert = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = {key_q, hit_handle_q, uses_inc};
    if (op_q == lfu_hc_pkg::OpLookup) begin
      if (hit_q) begin
        rsp_d.status     = lfu_hc_pkg::StHit;
        rsp_d.handle_out = hit_handle_q;
        ram_we           = fin_go;
      end else begin
        rsp_d.status = lfu_hc_pkg::StMiss;
      end
    end else if (hit_q) begin
      rsp_d.status = lfu_hc_pkg::StDuplicate;
    end else begin
      do_insert = 1'b1;
      ram_we    = fin_go;
      ram_wdata = {key_q, handle_q, COUNT_BITS'(1)};
      if (free_found_q) begin
        rsp_d.status = lfu_hc_pkg::StInserted;
        ram_waddr    = free_idx_q;
      end else begin
        rsp_d.status      = lfu_hc_pkg::StEvicted;
        rsp_d.evicted_key = ev_ext[31:0];
        ram_waddr         = vic_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      op_q         <= lfu_hc_pkg::OpLookup;
      key_q        <= '0;
      handle_q     <= '0;
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_handle_q <= '0;
      hit_uses_q   <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      vic_found_q  <= 1'b0;
      vic_idx_q    <= '0;
      vic_key_q    <= '0;
      vic_uses_q   <= '0;
      valid_q      <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
    end else begin
      cmp_vld_q <= (state_q == StScan);
      cmp_idx_q <= rd_idx_q;

      if (slot_match) begin
        hit_q        <= 1'b1;
        hit_idx_q    <= cmp_idx_q;
        hit_handle_q <= rd_handle;
        hit_uses_q   <= rd_uses;
      end
      if (slot_free) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end
      if (vic_take) begin
        vic_found_q <= 1'b1;
        vic_idx_q   <= cmp_idx_q;
        vic_key_q   <= rd_key;
        vic_uses_q  <= rd_uses;
      end

      // a new response replaces one taken in the same cycle
      if (fin_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (req_fire) begin
            op_q         <= req_i.op;
            key_q        <= req_key;
            handle_q     <= req_i.handle;
            rd_idx_q     <= '0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            vic_found_q  <= 1'b0;
            state_q      <= StScan;
          end
        end
        StScan: begin
          if (rd_idx_q == LastIdx) begin
            state_q <= StDrain;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        StDrain: begin
          state_q <= StFinish;
        end
        StFinish: begin
          if (fin_go) begin
            rsp_q <= rsp_d;
            if (do_insert) begin
              valid_q[ram_waddr] <= 1'b1;
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // eviction only ever happens with a full table
  `LFU_ASSERT(a_evict_only_full, (state_q == StFinish && !free_found_q) |-> (&valid_q),
              "victim chosen while a free slot exists")
  // slots are never released
  `LFU_ASSERT(a_valid_monotonic, $countones(valid_q) >= $past($countones(valid_q)),
              "valid slot count dropped")
  // an insert marks its slot valid
  `LFU_ASSERT(a_insert_sets_valid, (fin_go && do_insert) |=> valid_q[$past(ram_waddr)],
              "inserted slot not marked valid")
  // the RAM is written only in the finish cycle
  `LFU_ASSERT_NEVER(a_no_stray_write, ram_we && (state_q != StFinish),
                    "RAM written outside the finish cycle")

endmodule

`default_nettype wire

### rtl/core/lfu_hc_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module lfu_hc_ram #(
  parameter int unsigned DEPTH = 10,
  parameter int unsigned WIDTH = 112,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
